/* hw/rtl/shr_pkg.sv */
// Shared types, codes and constants for the single-wire humidity sensor reader.
package shr_pkg;

    // Register map and data port geometry.
    localparam int ADDR_WIDTH = 4;
    localparam int DATA_WIDTH = 32;
    localparam logic [1:0] REG_START_LOW = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_TIMEOUT   = 2'd2;

    // Register reset values.
    localparam logic [15:0] START_LOW_RESET = 16'd20000;
    localparam logic [7:0]  THRESHOLD_RESET = 8'd40;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;

    // Width of the tick counter.
    localparam int COUNT_WIDTH_DEF = 16;

    // Number of data bits in one frame.
    localparam logic [5:0] FRAME_BITS = 6'd40;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CHECKSUM = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;

    // Sign bit and magnitude mask of the temperature high byte.
    localparam logic [7:0] TEMP_SIGN_MASK = 8'h80;
    localparam logic [7:0] TEMP_MAG_MASK  = 8'h7F;

    typedef enum logic [2:0] {
        PH_IDLE          = 3'd0,
        PH_START_LOW     = 3'd1,
        PH_WAIT_HIGH     = 3'd2,
        PH_WAIT_RESP_LOW = 3'd3,
        PH_RESP_LOW      = 3'd4,
        PH_RESP_HIGH     = 3'd5,
        PH_BIT_LOW       = 3'd6,
        PH_BIT_HIGH      = 3'd7
    } t_phase;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  one_threshold_ticks;
        logic [15:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic        drive_low;
        logic        reading_valid;
        logic [1:0]  status;
        logic [15:0] humidity_tenths;
        logic [14:0] temp_magnitude_tenths;
        logic        temp_negative;
    } t_result;

endpackage

/* hw/rtl/shr_in_if.sv */
// Input channel: one tick with the sampled line level and a start request.
interface shr_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic line_level;

    modport source (output valid, output operation, output line_level, input ready);
    modport sink (input valid, input operation, input line_level, output ready);
endinterface

/* hw/rtl/shr_out_if.sv */
// Output channel: one result per tick with line drive and frame reading.
interface shr_out_if;
    logic        valid;
    logic        ready;
    logic        drive_low;
    logic        reading_valid;
    logic [1:0]  status;
    logic [15:0] humidity_tenths;
    logic [14:0] temp_magnitude_tenths;
    logic        temp_negative;

    modport source (
        output valid, output drive_low, output reading_valid, output status,
        output humidity_tenths, output temp_magnitude_tenths, output temp_negative,
        input ready
    );
    modport sink (
        input valid, input drive_low, input reading_valid, input status,
        input humidity_tenths, input temp_magnitude_tenths, input temp_negative,
        output ready
    );
endinterface

/* hw/rtl/single_wire_humidity_sensor_reader_top.sv */
// Each result is decoded combinationally from its tick and registered in the queue before it is offered.
// Throughput: one tick per cycle while the queue has room; the sequencer decides each tick combinationally.
// A two-entry result queue keeps input accepted while one result waits downstream.
// Reset is synchronous and active low: the sequencer returns to idle, the queue empties
// and the configuration registers take their default values.
module single_wire_humidity_sensor_reader_top
    import shr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    shr_in_if.sink                i_in,
    shr_out_if.source             o_out
);

    t_cfg    cfg;
    t_result core_res;
    t_result q_data;
    logic    can_push;
    logic    in_fire;

    assign i_in.ready = can_push;
    assign in_fire    = i_in.valid && can_push;

    shr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    shr_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_fire),
        .i_operation  (i_in.operation),
        .i_line_level (i_in.line_level),
        .i_cfg        (cfg),
        .o_result     (core_res)
    );

    shr_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (in_fire),
        .i_data     (core_res),
        .o_can_push (can_push),
        .o_valid    (o_out.valid),
        .i_pop      (o_out.ready),
        .o_data     (q_data)
    );

    assign o_out.drive_low             = q_data.drive_low;
    assign o_out.reading_valid         = q_data.reading_valid;
    assign o_out.status                = q_data.status;
    assign o_out.humidity_tenths       = q_data.humidity_tenths;
    assign o_out.temp_magnitude_tenths = q_data.temp_magnitude_tenths;
    assign o_out.temp_negative         = q_data.temp_negative;

endmodule

/* hw/rtl/shr_cfg.sv */
// APB-style configuration registers of the sensor reader.
module shr_cfg
    import shr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_ticks     <= START_LOW_RESET;
            r_cfg.one_threshold_ticks <= THRESHOLD_RESET;
            r_cfg.timeout_ticks       <= TIMEOUT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_START_LOW: r_cfg.start_low_ticks     <= pwdata[15:0];
                REG_THRESHOLD: r_cfg.one_threshold_ticks <= pwdata[7:0];
                REG_TIMEOUT:   r_cfg.timeout_ticks       <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_START_LOW: prdata = {16'd0, r_cfg.start_low_ticks};
            REG_THRESHOLD: prdata = {24'd0, r_cfg.one_threshold_ticks};
            REG_TIMEOUT:   prdata = {16'd0, r_cfg.timeout_ticks};
            default:       prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/shr_core.sv */
// Frame sequencer: start pulse, response wait, bit timing and frame decode.
module shr_core
    import shr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_operation,
    input  logic    i_line_level,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam logic [31:0] CntMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [5:0]             r_bits, n_bits;
    logic [39:0]            r_shift, n_shift;

    logic                   frame_done;
    logic                   timed_out;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [31:0]            count_ext;
    logic [31:0]            start_lim;
    logic [31:0]            timeout_lim;
    logic [7:0]             b0, b1, b2, b3, b4;
    logic [7:0]             byte_sum;

    // Limits of zero act as one, and limits beyond the counter range act as its maximum.
    function automatic logic [31:0] clamp_limit(input logic [15:0] lim);
        logic [31:0] v;
        v = (lim == 16'd0) ? 32'd1 : {16'd0, lim};
        return (v > CntMax) ? CntMax : v;
    endfunction

    assign count_inc   = (32'(r_count) == CntMax) ? r_count : r_count + 1'b1;
    assign count_ext   = 32'(count_inc);
    assign start_lim   = clamp_limit(i_cfg.start_low_ticks);
    assign timeout_lim = clamp_limit(i_cfg.timeout_ticks);

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_bits     = r_bits;
        n_shift    = r_shift;
        frame_done = 1'b0;
        timed_out  = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_operation) begin
                    n_phase = PH_START_LOW;
                    n_count = COUNT_WIDTH'(1);
                    n_bits  = '0;
                    n_shift = '0;
                end
            end
            PH_START_LOW: begin
                if (32'(r_count) >= start_lim) begin
                    n_phase = PH_WAIT_HIGH;
                    n_count = '0;
                end else begin
                    n_count = count_inc;
                end
            end
            default: begin
                // Odd phases hold the line high, even phases hold it low.
                if (i_line_level == r_phase[0]) begin
                    n_count = count_inc;
                    if (count_ext >= timeout_lim) begin
                        n_phase   = PH_IDLE;
                        n_count   = '0;
                        timed_out = 1'b1;
                    end
                end else if (r_phase == PH_BIT_HIGH) begin
                    n_shift = {r_shift[38:0], (32'(r_count) > 32'(i_cfg.one_threshold_ticks))};
                    n_bits  = r_bits + 1'b1;
                    n_count = COUNT_WIDTH'(1);
                    if (n_bits >= FRAME_BITS) begin
                        frame_done = 1'b1;
                        n_phase    = PH_IDLE;
                        n_count    = '0;
                    end else begin
                        n_phase = PH_BIT_LOW;
                    end
                end else begin
                    n_phase = t_phase'(r_phase + 3'd1);
                    n_count = COUNT_WIDTH'(1);
                end
            end
        endcase
    end

    assign b0       = n_shift[39:32];
    assign b1       = n_shift[31:24];
    assign b2       = n_shift[23:16];
    assign b3       = n_shift[15:8];
    assign b4       = n_shift[7:0];
    assign byte_sum = b0 + b1 + b2 + b3;

    always_comb begin
        o_result                       = '0;
        o_result.drive_low             = (n_phase == PH_START_LOW);
        o_result.reading_valid         = frame_done || timed_out;
        if (timed_out) begin
            o_result.status = ST_TIMEOUT;
        end else if (frame_done) begin
            if (byte_sum != b4) begin
                o_result.status = ST_CHECKSUM;
            end else begin
                o_result.status                = ST_OK;
                o_result.humidity_tenths       = {b0, b1};
                o_result.temp_magnitude_tenths = {7'((b2 & TEMP_MAG_MASK)), b3};
                o_result.temp_negative         = ((b2 & TEMP_SIGN_MASK) != 8'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_bits  <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_bits  <= n_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_shift <= n_shift;
        end
    end

endmodule

/* hw/rtl/shr_outq.sv */
// Two-entry result queue between the sequencer and the output channel.
module shr_outq
    import shr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_can_push,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    t_result    r_ent [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push, do_pop;

    assign o_can_push = (r_cnt != 2'd2);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_data     = r_ent[r_rptr];
    assign do_push    = i_push && o_can_push;
    assign do_pop     = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wptr] <= i_data;
        end
    end

endmodule

/* test/single_wire_humidity_sensor_reader_top_tb.sv */
// Self-checking testbench for the single-wire humidity sensor reader top level.
module single_wire_humidity_sensor_reader_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import shr_pkg::*;

    // Register index that decodes to no register.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [DATA_WIDTH-1:0] pwdata;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    shr_in_if  in_ch ();
    shr_out_if out_ch ();

    single_wire_humidity_sensor_reader_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow of the sequencer state and registers.
    t_cfg        cfg_shadow;
    t_phase      mdl_phase;
    logic [15:0] mdl_count;
    logic [5:0]  mdl_bits;
    logic [39:0] mdl_shift;

    t_result     expected_tick_outputs[$];
    int unsigned ticks_sent;
    int unsigned mismatch_count;
    bit          idle_on;
    bit          stall_on;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("single_wire_humidity_sensor_reader_top test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    function automatic logic [15:0] eff_limit(input logic [15:0] lim);
        return (lim == 16'd0) ? 16'd1 : lim;
    endfunction

    task automatic sensor_model_reset();
        cfg_shadow.start_low_ticks     = START_LOW_RESET;
        cfg_shadow.one_threshold_ticks = THRESHOLD_RESET;
        cfg_shadow.timeout_ticks       = TIMEOUT_RESET;
        mdl_phase = PH_IDLE;
        mdl_count = '0;
        mdl_bits  = '0;
        mdl_shift = '0;
    endtask

    task automatic sensor_model_tick(input logic op, input logic lvl, output t_result res);
        logic [7:0] b0, b1, b2, b3, b4, sum;
        logic       bit_val;
        res = '0;
        if (mdl_phase == PH_IDLE) begin
            if (op) begin
                mdl_phase = PH_START_LOW;
                mdl_count = 16'd1;
                mdl_bits  = '0;
                mdl_shift = '0;
            end
        end else if (mdl_phase == PH_START_LOW) begin
            if (mdl_count >= eff_limit(cfg_shadow.start_low_ticks)) begin
                mdl_phase = PH_WAIT_HIGH;
                mdl_count = '0;
            end else if (mdl_count != '1) begin
                mdl_count++;
            end
        end else if (lvl == mdl_phase[0]) begin
            // Odd phases hold the line high, even phases hold it low.
            if (mdl_count != '1) begin
                mdl_count++;
            end
            if (mdl_count >= eff_limit(cfg_shadow.timeout_ticks)) begin
                mdl_phase = PH_IDLE;
                mdl_count = '0;
                res.reading_valid = 1'b1;
                res.status = ST_TIMEOUT;
            end
        end else if (mdl_phase == PH_BIT_HIGH) begin
            bit_val = (mdl_count > {8'd0, cfg_shadow.one_threshold_ticks});
            mdl_shift = {mdl_shift[38:0], bit_val};
            mdl_bits++;
            mdl_count = 16'd1;
            if (mdl_bits >= FRAME_BITS) begin
                {b0, b1, b2, b3, b4} = mdl_shift;
                sum = b0 + b1 + b2 + b3;
                res.reading_valid = 1'b1;
                if (sum != b4) begin
                    res.status = ST_CHECKSUM;
                end else begin
                    res.humidity_tenths = {b0, b1};
                    res.temp_magnitude_tenths = {b2[6:0] & TEMP_MAG_MASK[6:0], b3};
                    res.temp_negative = |(b2 & TEMP_SIGN_MASK);
                end
                mdl_phase = PH_IDLE;
                mdl_count = '0;
            end else begin
                mdl_phase = PH_BIT_LOW;
            end
        end else begin
            mdl_phase = t_phase'(mdl_phase + 3'd1);
            mdl_count = 16'd1;
        end
        res.drive_low = (mdl_phase == PH_START_LOW);
    endtask

    function automatic int idle_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic noise_op();
        return ($urandom_range(0, 7) == 0);
    endfunction

    // Output back-pressure: mostly short stalls, now and then a long one.
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!stall_on) begin
                stall_left = 0;
                out_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                           : $urandom_range(10, 40);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.drive_low             = out_ch.drive_low;
            got.reading_valid         = out_ch.reading_valid;
            got.status                = out_ch.status;
            got.humidity_tenths       = out_ch.humidity_tenths;
            got.temp_magnitude_tenths = out_ch.temp_magnitude_tenths;
            got.temp_negative         = out_ch.temp_negative;
            if (expected_tick_outputs.size() == 0) begin
                report_mismatch("result transaction with nothing pending");
            end else begin
                want = expected_tick_outputs.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf(
                        {"expected dl=%0b rv=%0b st=%0d hum=%0d temp=%0d neg=%0b, ",
                         "got dl=%0b rv=%0b st=%0d hum=%0d temp=%0d neg=%0b"},
                        want.drive_low, want.reading_valid, want.status,
                        want.humidity_tenths, want.temp_magnitude_tenths, want.temp_negative,
                        got.drive_low, got.reading_valid, got.status,
                        got.humidity_tenths, got.temp_magnitude_tenths, got.temp_negative));
                end
            end
        end
    end

    task automatic drive_tick(input logic op, input logic lvl);
        t_result res;
        int      gap;
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.line_level <= lvl;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sensor_model_tick(op, lvl, res);
        expected_tick_outputs.push_back(res);
        ticks_sent++;
        gap = idle_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic release_input();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_results_drained();
        while (expected_tick_outputs.size() != 0) @(posedge i_clk);
    endtask

    task automatic drive_level_run(input logic lvl, input int n);
        repeat (n) drive_tick(noise_op(), lvl);
    endtask

    // Holding one level always ends the frame: either it completes or it times out.
    task automatic drain_to_idle();
        logic lvl;
        lvl = 1'($urandom_range(0, 1));
        while (mdl_phase != PH_IDLE) drive_tick(1'b0, lvl);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_START_LOW: cfg_shadow.start_low_ticks     = val[15:0];
            REG_THRESHOLD: cfg_shadow.one_threshold_ticks = val[7:0];
            REG_TIMEOUT:   cfg_shadow.timeout_ticks       = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic check_register(input logic [1:0] idx);
        logic [31:0] want;
        logic [31:0] got;
        case (idx)
            REG_START_LOW: want = {16'd0, cfg_shadow.start_low_ticks};
            REG_THRESHOLD: want = {24'd0, cfg_shadow.one_threshold_ticks};
            default:       want = {16'd0, cfg_shadow.timeout_ticks};
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WIDTH'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (got !== want) begin
            report_mismatch($sformatf("register %0d read: expected %0h, got %0h",
                                      idx, want, got));
        end
    endtask

    // Registers change only with the sequencer idle and every result delivered.
    task automatic apply_config(input logic [15:0] start_low, input logic [7:0] threshold,
                                input logic [15:0] timeout_lim);
        logic [31:0] junk;
        drain_to_idle();
        release_input();
        wait_results_drained();
        repeat (2) @(posedge i_clk);
        junk = $urandom;
        apb_write(REG_START_LOW, {junk[31:16], start_low});
        apb_write(REG_THRESHOLD, {junk[23:0], threshold});
        apb_write(REG_TIMEOUT, {junk[15:0], timeout_lim});
    endtask

    task automatic drive_frame(input logic [31:0] payload, input bit bad_sum,
                               input int bits_to_send, input int pause_bit);
        logic [7:0]  sum;
        logic [39:0] frame;
        int          thr;
        int          hi;
        int          bit_idx;
        sum = payload[31:24] + payload[23:16] + payload[15:8] + payload[7:0];
        if (bad_sum) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        frame = {payload, sum};
        drive_tick(1'b1, 1'($urandom_range(0, 1)));
        while (mdl_phase == PH_START_LOW) drive_tick(noise_op(), 1'($urandom_range(0, 1)));
        // Release, then the sensor's low and high response pulses.
        drive_level_run(1'b0, $urandom_range(0, 3));
        drive_level_run(1'b1, $urandom_range(1, 4));
        drive_level_run(1'b0, $urandom_range(1, 4));
        drive_level_run(1'b1, $urandom_range(1, 4));
        for (bit_idx = 0; bit_idx < bits_to_send; bit_idx++) begin
            thr = cfg_shadow.one_threshold_ticks;
            drive_level_run(1'b0, $urandom_range(1, 3));
            if (frame[39 - bit_idx]) begin
                hi = thr + $urandom_range(1, 3);
            end else begin
                hi = $urandom_range(1, (thr > 0) ? thr : 1);
            end
            drive_level_run(1'b1, hi);
            if (bit_idx == pause_bit) begin
                release_input();
                wait_results_drained();
            end
        end
        if (bits_to_send == 40) begin
            drive_level_run(1'b0, 1);
        end
    endtask

    task automatic test_register_access();
        logic [1:0] idx;
        for (int i = 0; i < 3; i++) check_register(2'(i));
        for (int i = 0; i < 3; i++) begin
            idx = 2'(i);
            apb_write(idx, $urandom);
            check_register(REG_START_LOW);
            check_register(REG_THRESHOLD);
            check_register(REG_TIMEOUT);
        end
        // A write to an unmapped address must leave every register as it was.
        apb_write(REG_UNUSED, $urandom);
        for (int i = 0; i < 3; i++) check_register(2'(i));
    endtask

    task automatic test_start_and_timeout_limits();
        // Zero limits behave as one.
        apply_config(16'd0, THRESHOLD_RESET, 16'd0);
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b0, 1'b1);
        drive_tick(1'b1, 1'b0);
        drive_tick(1'b1, 1'b1);
        drive_tick(1'b1, 1'b0);
        drive_tick(1'b0, 1'b1);
        apply_config(16'd0, THRESHOLD_RESET, 16'd1);
        drive_tick(1'b1, 1'b1);
        drive_tick(1'b0, 1'b0);
        drive_tick(1'b0, 1'b1);
        drive_tick(1'b0, 1'b1);
        // Start requests while busy are ignored.
        apply_config(16'd2, THRESHOLD_RESET, 16'd2);
        drive_tick(1'b1, 1'b0);
        drive_tick(1'b1, 1'b1);
        drive_tick(1'b1, 1'b0);
        drive_tick(1'b1, 1'b0);
        drive_tick(1'b1, 1'b0);
        drive_tick(1'b0, 1'b0);
    endtask

    task automatic test_default_config_frame();
        apply_config(START_LOW_RESET, THRESHOLD_RESET, TIMEOUT_RESET);
        drive_tick(1'b1, 1'($urandom_range(0, 1)));
        drive_level_run(1'($urandom_range(0, 1)), 20);
        // The default start pulse is far longer than this run, so it is cut short
        // while it is held, with no transaction in flight.
        release_input();
        wait_results_drained();
        apb_write(REG_START_LOW, 32'd3);
        apb_write(REG_TIMEOUT, 32'd60);
        drive_frame($urandom, 1'b0, 2, -1);
        drain_to_idle();
    endtask

    task automatic test_random_frames();
        int unsigned first_tick;
        int          kind;
        int          pick;
        bit          paused;
        logic [31:0] payload;
        logic [7:0]  thr;
        first_tick = ticks_sent;
        paused = 1'b0;
        kind = 0;
        while (ticks_sent - first_tick < 200) begin
            if (ticks_sent == first_tick || $urandom_range(0, 3) == 0) begin
                thr = 8'($urandom_range(0, 3));
                apply_config(16'($urandom_range(0, 4)), thr,
                             16'(thr + $urandom_range(8, 30)));
            end
            idle_on  = ($urandom_range(0, 4) != 0);
            stall_on = ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 7);
            payload = (pick == 0) ? 32'h0000_0000 :
                      (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                drive_frame(payload, kind == 6, 40, paused ? -1 : $urandom_range(0, 39));
                paused = 1'b1;
            end else if (kind < 9) begin
                drive_frame(payload, 1'b0, $urandom_range(0, 39), -1);
                drain_to_idle();
            end else begin
                repeat ($urandom_range(10, 60)) begin
                    drive_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                drain_to_idle();
            end
            repeat ($urandom_range(0, 5)) drive_tick(1'b0, 1'($urandom_range(0, 1)));
        end
        idle_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    task automatic test_threshold_zero();
        apply_config(16'($urandom_range(1, 3)), 8'd0, 16'd12);
        drive_frame(32'hFFFF_FFFF, 1'b0, 40, -1);
    endtask

    task automatic test_extreme_limits();
        apply_config(16'hFFFF, 8'hFF, 16'hFFFF);
        check_register(REG_START_LOW);
        check_register(REG_THRESHOLD);
        check_register(REG_TIMEOUT);
        idle_on  = 1'b0;
        stall_on = 1'b0;
        drive_tick(1'b1, 1'($urandom_range(0, 1)));
        drive_level_run(1'($urandom_range(0, 1)), 10);
        idle_on  = 1'b1;
        stall_on = 1'b1;
        release_input();
        wait_results_drained();
        apb_write(REG_START_LOW, 32'd1);
        apb_write(REG_TIMEOUT, 32'd4);
        drain_to_idle();
    endtask

    initial begin
        sensor_model_reset();
        ticks_sent     = 0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        stall_on       = 1'b1;
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.operation  <= 1'b0;
        in_ch.line_level <= 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_start_and_timeout_limits();
        test_default_config_frame();
        test_random_frames();
        test_threshold_zero();
        test_extreme_limits();

        release_input();
        wait_results_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_tick_outputs.size() == 0) begin
            $display("single_wire_humidity_sensor_reader_top test passed");
        end else begin
            $display("single_wire_humidity_sensor_reader_top test failed");
        end
        $finish;
    end

endmodule
